// ----- hw/rtl/olist_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared sizes, request codes and cell command type for the ordered list.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FUNC_W = 3;

    // request codes
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd6;

    // per-cell update command
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_cmd_t;

endpackage

// ----- hw/rtl/olist_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds a value, loads or shifts from a neighbor, compares.
// ----------------------------------------------------------------------------
module olist_cell (
    input  logic                            aclk,
    input  olist_pkg::cell_cmd_t            cmd,
    input  logic [olist_pkg::DATA_W-1:0]    new_data,
    input  logic [olist_pkg::DATA_W-1:0]    left_data,
    input  logic [olist_pkg::DATA_W-1:0]    right_data,
    input  logic [olist_pkg::DATA_W-1:0]    key,
    output logic [olist_pkg::DATA_W-1:0]    data,
    output logic                            match
);

    logic [olist_pkg::DATA_W-1:0] data_reg;
    logic [olist_pkg::DATA_W-1:0] data_next;

    always_comb begin
        case (cmd)
            olist_pkg::CELL_LOAD:       data_next = new_data;
            olist_pkg::CELL_FROM_LEFT:  data_next = left_data;
            olist_pkg::CELL_FROM_RIGHT: data_next = right_data;
            default:                    data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

// ----- hw/rtl/olist_find.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_find
// First-hit priority encoder over the per-cell match flags.
// ----------------------------------------------------------------------------
module olist_find (
    input  logic [olist_pkg::DEPTH-1:0]  hits,
    output logic                         found,
    output logic [olist_pkg::POS_W-1:0]  position
);

    always_comb begin
        position = '0;
        for (int i = olist_pkg::DEPTH - 1; i >= 0; i--) begin
            if (hits[i]) begin
                position = olist_pkg::POS_W'(i);
            end
        end
        found = |hits;
    end

endmodule

// ----- hw/rtl/ordered_list_insert_remove_find_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_find_top
// Ordered list of up to DEPTH values built as a chain of shifting cells.
// A request (append, pop head, insert, remove, find, read, clear) is taken
// and its result transaction is presented from the output register on the
// next cycle. One request is taken per clock: all cells load, shift toward
// their left or right neighbor, or compare against the key in parallel, so
// the only limit on rate is the single output register, which frees up in
// the cycle its result is taken. Failed requests (full, empty, out of range,
// unused code) leave the list untouched and return ok low. Entries are not
// cleared by reset; fill is.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_find_top (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_func,
    input  logic signed [31:0]  s_value,
    input  logic [3:0]          s_position,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_ok,
    output logic signed [31:0]  m_read_value,
    output logic                m_found,
    output logic [3:0]          m_found_position,
    output logic [4:0]          m_fill_count,
    output logic                m_is_empty
);

    localparam int DEPTH  = olist_pkg::DEPTH;
    localparam int DATA_W = olist_pkg::DATA_W;
    localparam int POS_W  = olist_pkg::POS_W;
    localparam int CNT_W  = olist_pkg::CNT_W;

    // ---------------------------------------------------------------- state
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    logic             m_valid_reg;
    logic             ok_reg;
    logic [DATA_W-1:0] rd_reg;
    logic             found_reg;
    logic [POS_W-1:0] found_pos_reg;
    logic [CNT_W-1:0] cnt_reg;

    // ---------------------------------------------------------------- handshake
    // Output register frees in the same cycle its transaction is taken.
    logic accept;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // ---------------------------------------------------------------- cell chain
    logic [DATA_W-1:0]    key;
    logic [DATA_W-1:0]    cell_data [DEPTH];
    logic [DEPTH-1:0]     cell_match;
    logic [DEPTH-1:0]     hit_vec;
    olist_pkg::cell_cmd_t cell_cmd  [DEPTH];

    assign key = DATA_W'(s_value);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        // ends of the chain: head takes the key as its left source, tail keeps itself
        if (g == 0) begin : g_head
            assign left_d = key;
        end else begin : g_body_l
            assign left_d = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign right_d = cell_data[g];
        end else begin : g_body_r
            assign right_d = cell_data[g+1];
        end

        olist_cell u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd[g]),
            .new_data   (key),
            .left_data  (left_d),
            .right_data (right_d),
            .key        (key),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );

        // only occupied slots may report a hit
        assign hit_vec[g] = cell_match[g] && (CNT_W'(g) < fill_reg);
    end

    logic             find_hit;
    logic [POS_W-1:0] find_pos;

    olist_find u_find (
        .hits     (hit_vec),
        .found    (find_hit),
        .position (find_pos)
    );

    // ---------------------------------------------------------------- decode
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] rm_pos;
    logic             full;
    logic             empty;
    logic             ok;
    logic [DATA_W-1:0] rd;
    logic             hit_out;
    logic [POS_W-1:0] hit_pos_out;

    assign pos_ext = CNT_W'(s_position);
    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    // pop is a remove at the head
    assign rm_pos  = (s_func == olist_pkg::FN_POP) ? '0 : pos_ext;

    always_comb begin
        ok          = 1'b0;
        rd          = '0;
        hit_out     = 1'b0;
        hit_pos_out = '0;
        fill_next   = fill_reg;
        case (s_func)
            olist_pkg::FN_APPEND: begin
                ok = !full;
                if (ok) begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            olist_pkg::FN_POP, olist_pkg::FN_REMOVE: begin
                ok = (rm_pos < fill_reg);
                if (ok) begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            olist_pkg::FN_INSERT: begin
                ok = !full && (pos_ext <= fill_reg);
                if (ok) begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            olist_pkg::FN_FIND: begin
                ok          = find_hit;
                hit_out     = find_hit;
                hit_pos_out = find_hit ? find_pos : '0;
            end
            olist_pkg::FN_READ: begin
                ok = (pos_ext < fill_reg);
                if (ok) begin
                    rd = cell_data[s_position];
                end else if (!empty) begin
                    rd = cell_data[0];
                end
            end
            olist_pkg::FN_CLEAR: begin
                ok        = 1'b1;
                fill_next = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Per-cell commands; nothing moves unless the transaction succeeds.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_cmd[i] = olist_pkg::CELL_HOLD;
            if (accept && ok) begin
                case (s_func)
                    olist_pkg::FN_APPEND: begin
                        if (CNT_W'(i) == fill_reg) begin
                            cell_cmd[i] = olist_pkg::CELL_LOAD;
                        end
                    end
                    olist_pkg::FN_INSERT: begin
                        if (CNT_W'(i) == pos_ext) begin
                            cell_cmd[i] = olist_pkg::CELL_LOAD;
                        end else if (CNT_W'(i) > pos_ext) begin
                            cell_cmd[i] = olist_pkg::CELL_FROM_LEFT;
                        end
                    end
                    olist_pkg::FN_POP, olist_pkg::FN_REMOVE: begin
                        if (CNT_W'(i) >= rm_pos) begin
                            cell_cmd[i] = olist_pkg::CELL_FROM_RIGHT;
                        end
                    end
                    default: begin
                        cell_cmd[i] = olist_pkg::CELL_HOLD;
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg    <= fill_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg        <= ok;
            rd_reg        <= rd;
            found_reg     <= hit_out;
            found_pos_reg <= hit_pos_out;
            cnt_reg       <= fill_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = ok_reg;
    assign m_read_value     = 32'(rd_reg);
    assign m_found          = found_reg;
    assign m_found_position = 4'(found_pos_reg);
    assign m_fill_count     = 5'(cnt_reg);
    assign m_is_empty       = (cnt_reg == '0);

    // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds list depth");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (cnt_reg == fill_reg))
        else $error("reported fill count differs from list state");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> m_ok)
        else $error("find hit reported without success");
`endif

endmodule

// ----- bench/ordered_list_insert_remove_find_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_find_top_tb
// Self-checking bench for the ordered list. A short table of directed
// requests walks the empty, full and out-of-range corners. A long random run
// follows, biased in phases toward growing or shrinking the list. Every result
// transaction is checked field by field against a written-out value or a
// queue-based prediction of the list, with random stalls on both channels.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_find_top_tb;

    localparam int DEPTH  = olist_pkg::DEPTH;
    localparam int DATA_W = olist_pkg::DATA_W;
    localparam int POS_W  = olist_pkg::POS_W;
    localparam int CNT_W  = olist_pkg::CNT_W;
    localparam int FUNC_W = olist_pkg::FUNC_W;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int QUIET_TAIL     = 150;   // last random requests run with no stalls
    localparam int HOLDOFF_CYCLES = 80;    // long result-side stall
    localparam int HOLDOFF_AT     = 200;
    localparam int DRAIN_AT       = 500;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 30;
    localparam int NUM_ROWS       = 26;

    // code 7 is not an operation; the block must reject it untouched
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_value;
        logic              found;
        logic [POS_W-1:0]  found_position;
        logic [CNT_W-1:0]  fill_count;
        logic              is_empty;
    } list_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic [4:0]        reps;    // row sent this many times, value stepping by one
        logic              typed;   // want is written out below, else predicted
        list_result_t      want;
    } stim_row_t;

    localparam list_result_t NO_WANT    = '0;
    localparam list_result_t EMPTY_FAIL = '{1'b0, 32'h0, 1'b0, 4'd0, 5'd0, 1'b1};
    localparam list_result_t CLEARED    = '{1'b1, 32'h0, 1'b0, 4'd0, 5'd0, 1'b1};
    localparam list_result_t FULL_FAIL  = '{1'b0, 32'h0, 1'b0, 4'd0, 5'd16, 1'b0};

    // Directed requests. Bracketed comments give the list contents after the row.
    stim_row_t directed_rows [NUM_ROWS] = '{
        // rejected on an empty list
        '{olist_pkg::FN_POP,    32'h0000_0000, 4'd0,  5'd1, 1'b1, EMPTY_FAIL},
        '{olist_pkg::FN_REMOVE, 32'h0000_0000, 4'd0,  5'd1, 1'b1, EMPTY_FAIL},
        '{olist_pkg::FN_READ,   32'h0000_0000, 4'd0,  5'd1, 1'b1, EMPTY_FAIL},
        '{olist_pkg::FN_FIND,   32'h0000_0000, 4'd0,  5'd1, 1'b1, EMPTY_FAIL},
        '{FN_UNUSED,            32'hFFFF_FFFF, 4'd15, 5'd1, 1'b1, EMPTY_FAIL},
        '{olist_pkg::FN_INSERT, 32'h0000_1234, 4'd1,  5'd1, 1'b1, EMPTY_FAIL},
        '{olist_pkg::FN_CLEAR,  32'h0000_0000, 4'd0,  5'd1, 1'b1, CLEARED},
        // [8000_0000]
        '{olist_pkg::FN_INSERT, 32'h8000_0000, 4'd0,  5'd1, 1'b1,
          '{1'b1, 32'h0, 1'b0, 4'd0, 5'd1, 1'b0}},
        // [8000_0000 7FFF_FFFF]
        '{olist_pkg::FN_APPEND, 32'h7FFF_FFFF, 4'd0,  5'd1, 1'b1,
          '{1'b1, 32'h0, 1'b0, 4'd0, 5'd2, 1'b0}},
        // [8000_0000 7FFF_FFFF FFFF_FFFF]
        '{olist_pkg::FN_APPEND, 32'hFFFF_FFFF, 4'd0,  5'd1, 1'b1,
          '{1'b1, 32'h0, 1'b0, 4'd0, 5'd3, 1'b0}},
        // bad read hands back the head entry
        '{olist_pkg::FN_READ,   32'h0000_0000, 4'd15, 5'd1, 1'b1,
          '{1'b0, 32'h8000_0000, 1'b0, 4'd0, 5'd3, 1'b0}},
        '{olist_pkg::FN_FIND,   32'h7FFF_FFFF, 4'd0,  5'd1, 1'b1,
          '{1'b1, 32'h0, 1'b1, 4'd1, 5'd3, 1'b0}},
        '{olist_pkg::FN_FIND,   32'h0000_0000, 4'd0,  5'd1, 1'b1,
          '{1'b0, 32'h0, 1'b0, 4'd0, 5'd3, 1'b0}},
        // insert at the tail, then at the head
        '{olist_pkg::FN_INSERT, 32'h0000_0000, 4'd3,  5'd1, 1'b0, NO_WANT},
        '{olist_pkg::FN_INSERT, 32'h5555_5555, 4'd0,  5'd1, 1'b0, NO_WANT},
        '{olist_pkg::FN_READ,   32'h0000_0000, 4'd4,  5'd1, 1'b0, NO_WANT},
        '{olist_pkg::FN_REMOVE, 32'h0000_0000, 4'd2,  5'd1, 1'b0, NO_WANT},
        '{olist_pkg::FN_REMOVE, 32'h0000_0000, 4'd15, 5'd1, 1'b1,
          '{1'b0, 32'h0, 1'b0, 4'd0, 5'd4, 1'b0}},
        '{olist_pkg::FN_POP,    32'h0000_0000, 4'd0,  5'd1, 1'b0, NO_WANT},
        // three entries left; fill to the top
        '{olist_pkg::FN_APPEND, 32'hAAAA_0000, 4'd0,  5'd7, 1'b0, NO_WANT},
        '{olist_pkg::FN_INSERT, 32'h0F0F_0000, 4'd1,  5'd6, 1'b0, NO_WANT},
        '{olist_pkg::FN_APPEND, 32'h0000_0001, 4'd0,  5'd1, 1'b1, FULL_FAIL},
        '{olist_pkg::FN_INSERT, 32'h0000_0001, 4'd0,  5'd1, 1'b1, FULL_FAIL},
        '{olist_pkg::FN_FIND,   32'hAAAA_0006, 4'd0,  5'd1, 1'b0, NO_WANT},
        '{olist_pkg::FN_REMOVE, 32'h0000_0000, 4'd15, 5'd1, 1'b0, NO_WANT},
        '{olist_pkg::FN_CLEAR,  32'h0000_0000, 4'd0,  5'd1, 1'b1, CLEARED}
    };

    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic [2:0]                s_func     = '0;
    logic signed [31:0]        s_value    = '0;
    logic [3:0]                s_position = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic                      m_ok;
    logic signed [31:0]        m_read_value;
    logic                      m_found;
    logic [3:0]                m_found_position;
    logic [4:0]                m_fill_count;
    logic                      m_is_empty;

    logic [DATA_W-1:0] list_contents [$];     // predicted list, head at index 0
    list_result_t      pending_results [$];   // results owed by the block, oldest first
    int                error_count     = 0;
    int                stall_cycles    = 0;
    bit                quiet_tail      = 1'b0;
    bit                hold_results    = 1'b0;

    ordered_list_insert_remove_find_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_value          (s_value),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_read_value     (m_read_value),
        .m_found          (m_found),
        .m_found_position (m_found_position),
        .m_fill_count     (m_fill_count),
        .m_is_empty       (m_is_empty)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Prediction: apply one request to the list and return what the block
    // should answer. Only entries below the fill count are ever looked at.
    // ------------------------------------------------------------------------
    function automatic list_result_t list_apply(logic [FUNC_W-1:0] func,
                                                logic [DATA_W-1:0] value,
                                                logic [POS_W-1:0] position);
        list_result_t r;
        int           n;
        r = '0;
        n = list_contents.size();
        case (func)
            olist_pkg::FN_APPEND: begin
                if (n < DEPTH) begin
                    list_contents.push_back(value);
                    r.ok = 1'b1;
                end
            end
            olist_pkg::FN_POP: begin
                if (n > 0) begin
                    void'(list_contents.pop_front());
                    r.ok = 1'b1;
                end
            end
            olist_pkg::FN_INSERT: begin
                if (n < DEPTH && position <= n) begin
                    list_contents.insert(position, value);
                    r.ok = 1'b1;
                end
            end
            olist_pkg::FN_REMOVE: begin
                if (position < n) begin
                    list_contents.delete(position);
                    r.ok = 1'b1;
                end
            end
            olist_pkg::FN_FIND: begin
                for (int i = 0; i < n; i++) begin
                    if (!r.found && list_contents[i] == value) begin
                        r.found          = 1'b1;
                        r.found_position = POS_W'(i);
                    end
                end
                r.ok = r.found;
            end
            olist_pkg::FN_READ: begin
                if (position < n) begin
                    r.read_value = list_contents[position];
                    r.ok         = 1'b1;
                end else if (n > 0) begin
                    r.read_value = list_contents[0];
                end
            end
            olist_pkg::FN_CLEAR: begin
                list_contents.delete();
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.fill_count = CNT_W'(list_contents.size());
        r.is_empty   = (list_contents.size() == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Request side. Present one transaction, hold it until taken, record what
    // it should produce, then maybe idle. The valid is only lowered on a step
    // where it is not also raised for the next request.
    // ------------------------------------------------------------------------
    task automatic offer_request(input logic [FUNC_W-1:0] func,
                                 input logic [DATA_W-1:0] value,
                                 input logic [POS_W-1:0] position,
                                 input logic typed, input list_result_t want,
                                 input bit drain_after);
        list_result_t predicted;
        int           gap;
        s_valid    <= 1'b1;
        s_func     <= func;
        s_value    <= value;
        s_position <= position;
        do @(posedge aclk); while (!s_ready);
        predicted = list_apply(func, value, position);
        pending_results.push_back(typed ? want : predicted);

        gap = 0;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0 || drain_after) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // pause the request side until the block has answered everything
            while (drain_after && pending_results.size() != 0) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side ready: random stall bursts, plus one long hold-off on
    // request so the output register backs up into the request channel.
    // ------------------------------------------------------------------------
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // compare each result transaction with the oldest outstanding prediction
    always @(posedge aclk) begin : result_check
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("ok",             32'(m_ok),             32'(want.ok));
                check_field("read_value",     m_read_value,          want.read_value);
                check_field("found",          32'(m_found),          32'(want.found));
                check_field("found_position", 32'(m_found_position),
                            32'(want.found_position));
                check_field("fill_count",     32'(m_fill_count),     32'(want.fill_count));
                check_field("is_empty",       32'(m_is_empty),       32'(want.is_empty));
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
        bit                grow;
        int                roll;
        int                top;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                offer_request(directed_rows[r].func, directed_rows[r].value + DATA_W'(k),
                              directed_rows[r].position, directed_rows[r].typed,
                              directed_rows[r].want, 1'b0);
            end
        end

        // Random phase. The grow/shrink bias is redrawn every 64 requests so the
        // list keeps passing through empty and full. Half the values come from
        // the list itself so finds hit, and most positions land in range.
        grow = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                grow = 1'($urandom_range(0, 1));
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_TAIL);
            if (n == HOLDOFF_AT)
                hold_results = 1'b1;

            roll = $urandom_range(0, 99);
            if (grow)
                func = (roll < 30) ? olist_pkg::FN_APPEND :
                       (roll < 60) ? olist_pkg::FN_INSERT :
                       (roll < 68) ? olist_pkg::FN_POP    :
                       (roll < 76) ? olist_pkg::FN_REMOVE :
                       (roll < 87) ? olist_pkg::FN_FIND   :
                       (roll < 98) ? olist_pkg::FN_READ   :
                       (roll < 99) ? olist_pkg::FN_CLEAR  : FN_UNUSED;
            else
                func = (roll < 12) ? olist_pkg::FN_APPEND :
                       (roll < 24) ? olist_pkg::FN_INSERT :
                       (roll < 48) ? olist_pkg::FN_POP    :
                       (roll < 72) ? olist_pkg::FN_REMOVE :
                       (roll < 85) ? olist_pkg::FN_FIND   :
                       (roll < 98) ? olist_pkg::FN_READ   :
                       (roll < 99) ? olist_pkg::FN_CLEAR  : FN_UNUSED;

            roll = $urandom_range(0, 9);
            if (list_contents.size() != 0 && roll < 5)
                value = list_contents[$urandom_range(0, list_contents.size() - 1)];
            else if (roll < 7)
                value = $urandom_range(0, 3);
            else
                value = $urandom;

            top = (list_contents.size() > 15) ? 15 : list_contents.size();
            if ($urandom_range(0, 4) != 0)
                position = POS_W'($urandom_range(0, top));
            else
                position = POS_W'($urandom_range(0, 15));

            offer_request(func, value, position, 1'b0, NO_WANT, n == DRAIN_AT);
        end
        // the last request has been taken; stop offering it
        s_valid <= 1'b0;

        // wait out the last results, then keep watching for any stray one
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
